// ----- sv/ddf_pkg.sv -----
// shared types and constants of the diagonal difference filter
package ddf_pkg;

    localparam int PIX_W        = 8;
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;
    // ring length 2*w+2 fits in 13 bits for any 11-bit width
    localparam int DEPTH_W      = 13;
    localparam int DIAG_OFFSET  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd1024;

    typedef struct packed {
        logic has_result;
        logic filter;
        logic last;
    } item_info_t;

endpackage

// ----- sv/diagonal_difference_filter_core.sv -----
// top level of the diagonal difference filter
//
// input channel: in_valid / in_ready with pixel_in, one grey word per pixel in
// raster order; after the frame's w*h pixels send 2*w+2 padding words to flush.
// output channel: out_valid / out_ready with pixel_out and frame_end; each
// output word is the pixel two lines plus two pixels back, minus its lower-right
// diagonal partner, clamped at zero; border pixels pass unchanged.
// frame_end marks the last pixel of the frame.
// configuration: cfg_write, cfg_index, cfg_data; index 0 image width, index 1
// image height; written while the block is idle.
// throughput: one word per cycle while in_ready is high, set by the single ring memory port that reads
// and writes one entry per accepted word.
// an accepted partner word is held in the read stage (ram read), then in the output
// register that drives out_valid.
// the first 2*w+2 words of a frame give no output.
// reset clears counters and sets width and height to 1024; ring contents
// need no clearing since they are written before being read.
// when the receiver stalls, one result waits in the output register and one in
// the read stage; in_ready drops only when both are full.
module diagonal_difference_filter_core
    import ddf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PIX_W-1:0]       pixel_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PIX_W-1:0]       pixel_out,
    output logic                   frame_end,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int RING_DEPTH = 2 * MAX_WIDTH + 2;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    logic             accept;
    logic             take;
    logic [PTR_W-1:0] addr;
    logic [PIX_W-1:0] rd_data;
    item_info_t       info;

    assign in_ready = take;
    assign accept   = in_valid && take;

    ddf_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PTR_W      (PTR_W),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .addr      (addr),
        .info      (info)
    );

    ddf_ring_ram #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .en    (accept),
        .addr  (addr),
        .wdata (pixel_in),
        .rdata (rd_data)
    );

    ddf_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .info      (info),
        .pix       (pixel_in),
        .rd_data   (rd_data),
        .take      (take),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .pixel_out (pixel_out),
        .frame_end (frame_end)
    );

endmodule

// ----- sv/ddf_ring_ram.sv -----
// single-port read-first ring memory holding the delayed pixels
module ddf_ring_ram
    import ddf_pkg::*;
#(
    parameter int DEPTH  = 2050,
    parameter int ADDR_W = 12
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [PIX_W-1:0]  wdata,
    output logic [PIX_W-1:0]  rdata
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    // read returns the value stored before this write
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ddf_seq.sv -----
// configuration registers, ring pointer and raster position counters
module ddf_seq
    import ddf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int PTR_W      = 12,
    parameter int COL_W      = 10,
    parameter int ROW_W      = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [PTR_W-1:0]       addr,
    output item_info_t             info
);

    logic [WIDTH_CFG_W-1:0]  width_cfg_reg;
    logic [HEIGHT_CFG_W-1:0] height_cfg_reg;
    logic [PTR_W-1:0]        ptr_reg,   ptr_next;
    logic [DEPTH_W-1:0]      items_reg, items_next;
    logic [COL_W-1:0]        col_reg,   col_next;
    logic [ROW_W-1:0]        row_reg,   row_next;

    logic [WIDTH_CFG_W-1:0]  w;
    logic [HEIGHT_CFG_W-1:0] h;
    logic [DEPTH_W-1:0]      d;
    logic [PTR_W-1:0]        ptr_eff;
    logic [PTR_W:0]          ptr_inc;
    logic                    fill;
    logic                    filter;
    logic                    last;

    always_comb
    begin
        if (width_cfg_reg == '0)
            w = WIDTH_CFG_W'(1);
        else if (width_cfg_reg > MAX_WIDTH)
            w = WIDTH_CFG_W'(MAX_WIDTH);
        else
            w = width_cfg_reg;

        if (height_cfg_reg == '0)
            h = HEIGHT_CFG_W'(1);
        else if (height_cfg_reg > MAX_HEIGHT)
            h = HEIGHT_CFG_W'(MAX_HEIGHT);
        else
            h = height_cfg_reg;

        d = {1'b0, w, 1'b0} + DEPTH_W'(DIAG_OFFSET);

        // pointer left past the end by a shrinking width wraps first
        ptr_eff = (ptr_reg >= d) ? '0 : ptr_reg;
        ptr_inc = {1'b0, ptr_eff} + (PTR_W+1)'(1);

        fill   = items_reg < d;
        filter = (({1'b0, row_reg} + (ROW_W+1)'(DIAG_OFFSET)) < h)
              && (({1'b0, col_reg} + (COL_W+1)'(DIAG_OFFSET)) < w);
        last   = (({1'b0, row_reg} + (ROW_W+1)'(1)) >= h)
              && (({1'b0, col_reg} + (COL_W+1)'(1)) >= w);

        ptr_next   = (ptr_inc >= d) ? '0 : ptr_inc[PTR_W-1:0];
        items_next = items_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (fill)
        begin
            items_next = items_reg + DEPTH_W'(1);
        end
        else if (last)
        begin
            ptr_next   = '0;
            items_next = '0;
            col_next   = '0;
            row_next   = '0;
        end
        else if (({1'b0, col_reg} + (COL_W+1)'(1)) >= w)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
            ptr_reg        <= '0;
            items_reg      <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data[WIDTH_CFG_W-1:0];
                    CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data[HEIGHT_CFG_W-1:0];
                    default:          ;
                endcase
            end
            if (accept)
            begin
                ptr_reg   <= ptr_next;
                items_reg <= items_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
            end
        end
    end

    assign addr            = ptr_eff;
    assign info.has_result = !fill;
    assign info.filter     = filter;
    assign info.last       = last;

endmodule

// ----- sv/ddf_out.sv -----
// read-data stage, subtract and clamp, and output register
module ddf_out
    import ddf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  item_info_t       info,
    input  logic [PIX_W-1:0] pix,
    input  logic [PIX_W-1:0] rd_data,
    output logic             take,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [PIX_W-1:0] pixel_out,
    output logic             frame_end
);

    logic             s1_valid_reg;
    logic             s1_filter_reg;
    logic             s1_last_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_last_reg;

    logic             out_free;
    logic             s1_move;
    logic [PIX_W-1:0] res;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    // ram read data is held while the read stage waits, so no new word then
    assign take     = !s1_valid_reg || out_free;

    always_comb
    begin
        if (s1_filter_reg)
            res = (rd_data > s1_pix_reg) ? rd_data - s1_pix_reg : '0;
        else
            res = rd_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= info.has_result;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg    <= pix;
            s1_filter_reg <= info.filter;
            s1_last_reg   <= info.last;
        end
        if (s1_move)
        begin
            out_pix_reg  <= res;
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = out_pix_reg;
    assign frame_end = out_last_reg;

endmodule
